// ===== design/mxr_pkg.sv =====
// ----------------------------------------------------------------------------
// mxr_pkg: shared definitions of the five-port mesh router
// Port and command codes, register indexes, default widths and the
// arbitration/route decision that travels between the router modules.
// ----------------------------------------------------------------------------
package mxr_pkg;

    localparam int NUM_PORTS        = 5;
    localparam int PORT_BITS        = 3;
    localparam int DEF_COORD_BITS   = 16;
    localparam int DEF_PAYLOAD_BITS = 64;
    localparam int CFG_IDX_BITS     = 2;

    typedef enum logic [PORT_BITS-1:0] {
        PORT_LEFT  = 3'd0,
        PORT_RIGHT = 3'd1,
        PORT_UP    = 3'd2,
        PORT_DOWN  = 3'd3,
        PORT_LOCAL = 3'd4
    } t_port;

    typedef enum logic {
        CMD_RECEIVE = 1'b0,
        CMD_TICK    = 1'b1
    } t_cmd;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_X    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Y    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PORT_CONN = 2'd2;

    // Outcome of one arbitration and route computation.
    typedef struct packed {
        logic                 found;       // some buffer holds a packet
        logic [PORT_BITS-1:0] sel;         // buffer that won arbitration
        t_port                route;       // output port of its packet
        logic                 unconnected; // route leads to an unconnected port
        logic                 blocked;     // connected, but downstream refuses
    } t_route_dec;

endpackage

// ===== design/mxr_in_if.sv =====
// ----------------------------------------------------------------------------
// mxr_in_if: input channel of the mesh router
// Valid/ready channel that carries receive and tick items.
// ----------------------------------------------------------------------------
interface mxr_in_if #(
    parameter int COORD_BITS   = 16,
    parameter int PAYLOAD_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [2:0]              in_port;
    logic [COORD_BITS-1:0]   dest_x;
    logic [COORD_BITS-1:0]   dest_y;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [4:0]              downstream_busy;

    modport source (
        output valid, command, in_port, dest_x, dest_y, payload, downstream_busy,
        input  ready
    );
    modport sink (
        input  valid, command, in_port, dest_x, dest_y, payload, downstream_busy,
        output ready
    );
endinterface

// ===== design/mxr_out_if.sv =====
// ----------------------------------------------------------------------------
// mxr_out_if: result channel of the mesh router
// Valid/ready channel that carries one result item per input item.
// ----------------------------------------------------------------------------
interface mxr_out_if #(
    parameter int COORD_BITS   = 16,
    parameter int PAYLOAD_BITS = 64
);
    logic                    valid;
    logic                    ready;
    logic                    receive_refused;
    logic                    sent;
    logic [2:0]              out_port;
    logic [COORD_BITS-1:0]   out_dest_x;
    logic [COORD_BITS-1:0]   out_dest_y;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    route_error;

    modport source (
        output valid, receive_refused, sent, out_port, out_dest_x, out_dest_y,
               out_payload, route_error,
        input  ready
    );
    modport sink (
        input  valid, receive_refused, sent, out_port, out_dest_x, out_dest_y,
               out_payload, route_error,
        output ready
    );
endinterface

// ===== design/mxr_route.sv =====
// ----------------------------------------------------------------------------
// mxr_route: rotating arbiter and Y-then-X route computation
// Picks the first full buffer from the priority pointer and decides where
// its packet goes and whether that port can take it now.
// ----------------------------------------------------------------------------
module mxr_route
    import mxr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic [NUM_PORTS-1:0]  i_full,
    input  logic [COORD_BITS-1:0] i_buf_x [NUM_PORTS],
    input  logic [COORD_BITS-1:0] i_buf_y [NUM_PORTS],
    input  logic [PORT_BITS-1:0]  i_ptr,
    input  logic [COORD_BITS-1:0] i_node_x,
    input  logic [COORD_BITS-1:0] i_node_y,
    input  logic [NUM_PORTS-1:0]  i_connected,
    input  logic [NUM_PORTS-1:0]  i_busy,
    output t_route_dec            o_dec
);

    logic [PORT_BITS:0]    w_sum;
    logic [PORT_BITS-1:0]  w_idx;
    logic                  w_found;
    logic [PORT_BITS-1:0]  w_sel;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    t_port                 w_route;

    // Rotating priority scan over the five buffers.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        w_sum   = '0;
        w_idx   = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            w_sum = {1'b0, i_ptr} + (PORT_BITS+1)'(i);
            if (w_sum >= (PORT_BITS+1)'(NUM_PORTS)) begin
                w_sum = w_sum - (PORT_BITS+1)'(NUM_PORTS);
            end
            w_idx = w_sum[PORT_BITS-1:0];
            if (!w_found && i_full[w_idx]) begin
                w_found = 1'b1;
                w_sel   = w_idx;
            end
        end
    end

    assign w_dx = i_buf_x[w_sel];
    assign w_dy = i_buf_y[w_sel];

    always_comb begin
        priority if (w_dx == i_node_x && w_dy == i_node_y) begin
            w_route = PORT_LOCAL;
        end else if (w_dy < i_node_y) begin
            w_route = PORT_DOWN;
        end else if (w_dy > i_node_y) begin
            w_route = PORT_UP;
        end else if (w_dx < i_node_x) begin
            w_route = PORT_LEFT;
        end else begin
            w_route = PORT_RIGHT;
        end
    end

    always_comb begin
        o_dec.found       = w_found;
        o_dec.sel         = w_sel;
        o_dec.route       = w_route;
        o_dec.unconnected = !i_connected[w_route];
        o_dec.blocked     = i_connected[w_route] && i_busy[w_route];
    end

endmodule

// ===== design/mesh_router_xy_five_port.sv =====
// ----------------------------------------------------------------------------
// mesh_router_xy_five_port: five-port mesh router node, Y-then-X routing
//
//   channel  direction  handshake      contents
//   i_in     in         valid/ready    receive or tick item
//   o_out    out        valid/ready    one result item per input item
//   i_cfg_*  in         write enable   node_x, node_y, port_connected
//
// An item is taken into an input register, then arbitrated, routed and
// written to the result register; one item per cycle sustained while the
// result channel is not stalled. The input register advances whenever the
// result register is empty or being taken, so a stalled result holds at
// most two items inside. Reset empties all buffers and clears the pointer,
// the valid flags and the configuration; buffer contents are not reset.
// ----------------------------------------------------------------------------
module mesh_router_xy_five_port
    import mxr_pkg::*;
#(
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mxr_in_if.sink                   i_in,
    mxr_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [((COORD_BITS > NUM_PORTS) ? COORD_BITS : NUM_PORTS)-1:0] i_cfg_wdata
);

    // Configuration registers.
    logic [COORD_BITS-1:0]   r_node_x;
    logic [COORD_BITS-1:0]   r_node_y;
    logic [NUM_PORTS-1:0]    r_connected;

    // Input register.
    logic                    r_in_valid;
    t_cmd                    r_in_cmd;
    logic [PORT_BITS-1:0]    r_in_port;
    logic [COORD_BITS-1:0]   r_in_dx;
    logic [COORD_BITS-1:0]   r_in_dy;
    logic [PAYLOAD_BITS-1:0] r_in_payload;
    logic [NUM_PORTS-1:0]    r_in_busy;

    // Packet buffers and arbitration state.
    logic [NUM_PORTS-1:0]    r_full;
    logic [NUM_PORTS-1:0]    n_full;
    logic [COORD_BITS-1:0]   r_buf_x [NUM_PORTS];
    logic [COORD_BITS-1:0]   r_buf_y [NUM_PORTS];
    logic [PAYLOAD_BITS-1:0] r_buf_payload [NUM_PORTS];
    logic [PORT_BITS-1:0]    r_ptr;
    logic [PORT_BITS-1:0]    n_ptr;

    // Result register.
    logic                    r_out_valid;
    logic                    r_out_refused;
    logic                    n_out_refused;
    logic                    r_out_sent;
    logic                    n_out_sent;
    logic [PORT_BITS-1:0]    r_out_port;
    logic [PORT_BITS-1:0]    n_out_port;
    logic [COORD_BITS-1:0]   r_out_dx;
    logic [COORD_BITS-1:0]   n_out_dx;
    logic [COORD_BITS-1:0]   r_out_dy;
    logic [COORD_BITS-1:0]   n_out_dy;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    logic [PAYLOAD_BITS-1:0] n_out_payload;
    logic                    r_out_err;
    logic                    n_out_err;

    logic                    w_load_out;
    logic                    w_fire;
    logic                    w_store;
    t_route_dec              w_dec;

    assign w_load_out = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_load_out;
    assign i_in.ready = !r_in_valid || w_load_out;

    // A receive is stored only on a real port whose buffer is empty.
    assign w_store = (r_in_cmd == CMD_RECEIVE) &&
                     (r_in_port < PORT_BITS'(NUM_PORTS)) && !r_full[r_in_port];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_x    <= '0;
            r_node_y    <= '0;
            r_connected <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_X:    r_node_x    <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_NODE_Y:    r_node_y    <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_PORT_CONN: r_connected <= i_cfg_wdata[NUM_PORTS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd     <= t_cmd'(i_in.command);
            r_in_port    <= i_in.in_port;
            r_in_dx      <= i_in.dest_x;
            r_in_dy      <= i_in.dest_y;
            r_in_payload <= i_in.payload;
            r_in_busy    <= i_in.downstream_busy;
        end
    end

    mxr_route #(
        .COORD_BITS (COORD_BITS)
    ) u_route (
        .i_full      (r_full),
        .i_buf_x     (r_buf_x),
        .i_buf_y     (r_buf_y),
        .i_ptr       (r_ptr),
        .i_node_x    (r_node_x),
        .i_node_y    (r_node_y),
        .i_connected (r_connected),
        .i_busy      (r_in_busy),
        .o_dec       (w_dec)
    );

    always_comb begin
        n_full        = r_full;
        n_ptr         = r_ptr;
        n_out_refused = 1'b0;
        n_out_sent    = 1'b0;
        n_out_port    = '0;
        n_out_dx      = '0;
        n_out_dy      = '0;
        n_out_payload = '0;
        n_out_err     = 1'b0;
        unique case (r_in_cmd)
            CMD_RECEIVE: begin
                n_out_refused = !w_store;
                if (w_store) begin
                    n_full[r_in_port] = 1'b1;
                end
            end
            CMD_TICK: begin
                if (w_dec.found) begin
                    n_out_port = w_dec.route;
                    priority if (w_dec.unconnected) begin
                        n_out_err = 1'b1;
                    end else if (w_dec.blocked) begin
                        n_ptr = (r_ptr == PORT_BITS'(NUM_PORTS - 1)) ? '0 : r_ptr + 1'b1;
                    end else begin
                        n_out_sent          = 1'b1;
                        n_out_dx            = r_buf_x[w_dec.sel];
                        n_out_dy            = r_buf_y[w_dec.sel];
                        n_out_payload       = r_buf_payload[w_dec.sel];
                        n_full[w_dec.sel]   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_ptr  <= '0;
        end else if (w_fire) begin
            r_full <= n_full;
            r_ptr  <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_store) begin
            r_buf_x[r_in_port]       <= r_in_dx;
            r_buf_y[r_in_port]       <= r_in_dy;
            r_buf_payload[r_in_port] <= r_in_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_refused <= n_out_refused;
            r_out_sent    <= n_out_sent;
            r_out_port    <= n_out_port;
            r_out_dx      <= n_out_dx;
            r_out_dy      <= n_out_dy;
            r_out_payload <= n_out_payload;
            r_out_err     <= n_out_err;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.receive_refused = r_out_refused;
    assign o_out.sent            = r_out_sent;
    assign o_out.out_port        = r_out_port;
    assign o_out.out_dest_x      = r_out_dx;
    assign o_out.out_dest_y      = r_out_dy;
    assign o_out.out_payload     = r_out_payload;
    assign o_out.route_error     = r_out_err;

endmodule

// ===== tb/sv/mesh_router_xy_five_port_test.sv =====
// ----------------------------------------------------------------------------
// mesh_router_xy_five_port_test: self-checking bench of the mesh router node
// Drives receive and tick items through the input channel with random gaps,
// stalls the result channel at random, and checks every result item against
// a cycle-free prediction of the buffers, the rotating pointer and Y-then-X
// routing. The node position and the connected ports change between phases.
// ----------------------------------------------------------------------------
module mesh_router_xy_five_port_test;
    import mxr_pkg::*;

    localparam int CW        = DEF_COORD_BITS;
    localparam int PW        = DEF_PAYLOAD_BITS;
    localparam int CFG_W     = (CW > NUM_PORTS) ? CW : NUM_PORTS;
    localparam int IDLE_MAX  = 4000;
    localparam int PHASE_LEN = 206;

    typedef struct packed {
        t_cmd          cmd;
        logic [2:0]    port;
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [PW-1:0] pl;
        logic [4:0]    busy;
        logic          hold;   // wait for all results before sending
    } t_router_item;

    typedef struct packed {
        logic          refused;
        logic          sent;
        logic [2:0]    port;
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [PW-1:0] pl;
        logic          rerr;
    } t_route_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    mxr_in_if  #(.COORD_BITS(CW), .PAYLOAD_BITS(PW)) in_bus  ();
    mxr_out_if #(.COORD_BITS(CW), .PAYLOAD_BITS(PW)) out_bus ();

    mesh_router_xy_five_port #(
        .COORD_BITS  (CW),
        .PAYLOAD_BITS(PW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_router_item  items_to_send[$];
    t_route_result outcomes_due[$];

    // Predicted router state.
    logic [CW-1:0] node_x_reg = '0;
    logic [CW-1:0] node_y_reg = '0;
    logic [4:0]    conn_mask  = '0;
    logic          slot_full[NUM_PORTS] = '{default: 1'b0};
    logic [CW-1:0] slot_dx[NUM_PORTS];
    logic [CW-1:0] slot_dy[NUM_PORTS];
    logic [PW-1:0] slot_pl[NUM_PORTS];
    int            scan_ptr = 0;

    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    logic in_fire        = 1'b0;
    int   send_gap       = 0;
    int   send_quiet     = 0;
    int   recv_gap       = 0;
    int   recv_quiet     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones, and now and then a
    // quiet stretch with no gaps at all.
    function automatic int draw_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted item to the predicted state and returns its result.
    function automatic t_route_result arbitrate_and_route(input t_router_item it);
        t_route_result res;
        int            winner;
        int            idx;
        t_port         dir;
        res    = '0;
        winner = -1;
        if (it.cmd == CMD_RECEIVE) begin
            if (it.port >= NUM_PORTS || slot_full[it.port]) begin
                res.refused = 1'b1;
            end else begin
                slot_full[it.port] = 1'b1;
                slot_dx[it.port]   = it.dx;
                slot_dy[it.port]   = it.dy;
                slot_pl[it.port]   = it.pl;
            end
            return res;
        end
        for (int k = 0; k < NUM_PORTS; k++) begin
            idx = (k + scan_ptr) % NUM_PORTS;
            if (winner < 0 && slot_full[idx]) winner = idx;
        end
        if (winner < 0) return res;

        if (slot_dx[winner] == node_x_reg && slot_dy[winner] == node_y_reg) dir = PORT_LOCAL;
        else if (slot_dy[winner] < node_y_reg) dir = PORT_DOWN;
        else if (slot_dy[winner] > node_y_reg) dir = PORT_UP;
        else if (slot_dx[winner] < node_x_reg) dir = PORT_LEFT;
        else dir = PORT_RIGHT;

        res.port = dir;
        if (!conn_mask[dir]) begin
            res.rerr = 1'b1;
        end else if (it.busy[dir]) begin
            scan_ptr = (scan_ptr + 1) % NUM_PORTS;
        end else begin
            res.sent          = 1'b1;
            res.dx            = slot_dx[winner];
            res.dy            = slot_dy[winner];
            res.pl            = slot_pl[winner];
            slot_full[winner] = 1'b0;
        end
        return res;
    endfunction

    function automatic string fmt_result(input t_route_result r);
        return $sformatf("refused=%0b sent=%0b port=%0d x=%h y=%h payload=%h err=%0b",
                         r.refused, r.sent, r.port, r.dx, r.dy, r.pl, r.rerr);
    endfunction

    // Input driver: a new item goes out once the previous one was taken.
    always @(negedge i_clk) begin : feeder
        t_router_item nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (items_to_send.size() != 0 &&
                         !(items_to_send[0].hold && outcomes_due.size() != 0)) begin
                nxt = items_to_send.pop_front();
                in_bus.valid           <= 1'b1;
                in_bus.command         <= nxt.cmd;
                in_bus.in_port         <= nxt.port;
                in_bus.dest_x          <= nxt.dx;
                in_bus.dest_y          <= nxt.dy;
                in_bus.payload         <= nxt.pl;
                in_bus.downstream_busy <= nxt.busy;
                send_gap = draw_gap(send_quiet);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_stall
        if (recv_gap > 0) begin
            recv_gap--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
            recv_gap = draw_gap(recv_quiet);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_route_result seen;
        t_route_result due;
        t_router_item  taken;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                seen.refused = out_bus.receive_refused;
                seen.sent    = out_bus.sent;
                seen.port    = out_bus.out_port;
                seen.dx      = out_bus.out_dest_x;
                seen.dy      = out_bus.out_dest_y;
                seen.pl      = out_bus.out_payload;
                seen.rerr    = out_bus.route_error;
                if (outcomes_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result item: %s", fmt_result(seen));
                    mismatch_count++;
                end else begin
                    due = outcomes_due.pop_front();
                    if (due.refused !== seen.refused || due.sent !== seen.sent ||
                        due.port !== seen.port || due.dx !== seen.dx ||
                        due.dy !== seen.dy || due.pl !== seen.pl ||
                        due.rerr !== seen.rerr) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected %s", fmt_result(due));
                            $display("          actual   %s", fmt_result(seen));
                        end
                        mismatch_count++;
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                taken.cmd  = t_cmd'(in_bus.command);
                taken.port = in_bus.in_port;
                taken.dx   = in_bus.dest_x;
                taken.dy   = in_bus.dest_y;
                taken.pl   = in_bus.payload;
                taken.busy = in_bus.downstream_busy;
                taken.hold = 1'b0;
                outcomes_due.push_back(arbitrate_and_route(taken));
            end
            in_fire <= in_bus.valid && in_bus.ready;
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic queue_receive(input logic [2:0] port, input logic [CW-1:0] dx,
                                 input logic [CW-1:0] dy, input logic [PW-1:0] pl,
                                 input logic hold = 1'b0);
        t_router_item it;
        it.cmd  = CMD_RECEIVE;
        it.port = port;
        it.dx   = dx;
        it.dy   = dy;
        it.pl   = pl;
        it.busy = 5'($urandom);
        it.hold = hold;
        items_to_send.push_back(it);
    endtask

    task automatic queue_tick(input logic [4:0] busy, input logic hold = 1'b0);
        t_router_item it;
        it.cmd  = CMD_TICK;
        it.port = 3'($urandom);
        it.dx   = CW'($urandom);
        it.dy   = CW'($urandom);
        it.pl   = {$urandom, $urandom};
        it.busy = busy;
        it.hold = hold;
        items_to_send.push_back(it);
    endtask

    // Destinations cluster around the node so that every route comes up.
    function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] home);
        case ($urandom_range(0, 5))
            0, 1:    return home;
            2:       return home - CW'($urandom_range(1, 3));
            3:       return home + CW'($urandom_range(1, 3));
            4:       return $urandom_range(0, 1) ? {CW{1'b1}} : {CW{1'b0}};
            default: return CW'($urandom);
        endcase
    endfunction

    // Bursts of receives followed by bursts of ticks, with some receives on
    // ports that do not exist mixed in.
    task automatic queue_random_traffic(input int count);
        int   made;
        int   n_rx;
        int   n_tk;
        logic [2:0] port;
        logic [4:0] busy;
        logic hold;
        made = 0;
        while (made < count) begin
            n_rx = $urandom_range(0, 5);
            n_tk = $urandom_range(1, 6);
            for (int k = 0; k < n_rx; k++) begin
                if ($urandom_range(0, 9) == 0) port = 3'($urandom_range(5, 7));
                else port = 3'($urandom_range(0, 4));
                hold = (made == 60) || ($urandom_range(0, 99) == 0);
                queue_receive(port, pick_coord(node_x_reg), pick_coord(node_y_reg),
                              {$urandom, $urandom}, hold);
                made++;
            end
            for (int k = 0; k < n_tk; k++) begin
                busy = $urandom_range(0, 1) ? 5'd0 : 5'($urandom);
                hold = (made == 60) || ($urandom_range(0, 99) == 0);
                queue_tick(busy, hold);
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        wait (items_to_send.size() == 0 && !in_bus.valid && outcomes_due.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure_node(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic [4:0] conn);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_NODE_X;
        i_cfg_wdata <= CFG_W'(x);
        @(negedge i_clk);
        i_cfg_idx   <= CFG_NODE_Y;
        i_cfg_wdata <= CFG_W'(y);
        @(negedge i_clk);
        i_cfg_idx   <= CFG_PORT_CONN;
        i_cfg_wdata <= CFG_W'(conn);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        node_x_reg = x;
        node_y_reg = y;
        conn_mask  = conn;
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_NODE_X;
        i_cfg_wdata            = '0;
        in_bus.valid           = 1'b0;
        in_bus.command         = CMD_RECEIVE;
        in_bus.in_port         = '0;
        in_bus.dest_x          = '0;
        in_bus.dest_y          = '0;
        in_bus.payload         = '0;
        in_bus.downstream_busy = '0;
        out_bus.ready          = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: node at the origin, no port connected.
        queue_tick(5'd0);
        queue_receive(PORT_LEFT, 16'h0000, 16'h0000, 64'h0);
        queue_receive(PORT_LEFT, 16'hFFFF, 16'hFFFF, {PW{1'b1}});
        queue_receive(3'd5, 16'h1234, 16'h5678, {$urandom, $urandom});
        queue_receive(3'd6, 16'h0001, 16'h0002, {$urandom, $urandom});
        queue_receive(3'd7, 16'hFFFF, 16'h0000, {$urandom, $urandom});
        queue_tick(5'h1F);
        wait_drained();

        // Centered node, all ports connected: every route, busy ticks on empty buffers.
        configure_node(16'h8000, 16'h8000, 5'h1F);
        queue_tick(5'h1F);
        queue_tick(5'h17);
        queue_receive(PORT_RIGHT, 16'h8000, 16'h8000, {PW{1'b1}});
        queue_receive(PORT_UP, 16'h0000, 16'hFFFF, {$urandom, $urandom});
        queue_receive(PORT_DOWN, 16'h0000, 16'h8000, {$urandom, $urandom});
        queue_receive(PORT_LOCAL, 16'hFFFF, 16'h8000, {$urandom, $urandom});
        queue_receive(PORT_LEFT, 16'hFFFF, 16'h0000, {$urandom, $urandom});
        repeat (5) queue_tick(5'd0);
        queue_tick(5'd0);
        wait_drained();

        configure_node(16'h0000, 16'h0000, 5'h1F);
        queue_random_traffic(PHASE_LEN);
        wait_drained();

        configure_node(16'hFFFF, 16'hFFFF, 5'($urandom));
        queue_random_traffic(PHASE_LEN);
        wait_drained();

        configure_node(CW'($urandom), CW'($urandom), 5'h1F);
        queue_random_traffic(PHASE_LEN);
        wait_drained();

        configure_node(16'h8000, 16'h0001, 5'b01011);
        queue_random_traffic(PHASE_LEN);
        wait_drained();

        configure_node(CW'($urandom), CW'($urandom), 5'($urandom));
        queue_random_traffic(PHASE_LEN);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mxr_pkg.sv
design/mxr_in_if.sv
design/mxr_out_if.sv
design/mxr_route.sv
design/mesh_router_xy_five_port.sv
tb/sv/mesh_router_xy_five_port_test.sv
